// ===== rtl/i2cmts_pkg.sv =====
package i2cmts_pkg;

  localparam int BufDepth = 32;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int IdxW     = $clog2(BufDepth + 1);
  localparam int CmpW     = ((IdxW > 6) ? IdxW : 6) + 1;

  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_WRITE  = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;
  localparam logic [1:0] FN_STATUS = 2'd3;

  localparam logic [1:0] AC_OK      = 2'd0;
  localparam logic [1:0] AC_BAD_LEN = 2'd1;
  localparam logic [1:0] AC_BUSY    = 2'd2;

  localparam logic [2:0] MS_IDLE      = 3'd0;
  localparam logic [2:0] MS_BUSY      = 3'd1;
  localparam logic [2:0] MS_OK        = 3'd2;
  localparam logic [2:0] MS_NO_DATA   = 3'd3;
  localparam logic [2:0] MS_NACK_ADDR = 3'd4;
  localparam logic [2:0] MS_NACK_DATA = 3'd5;
  localparam logic [2:0] MS_ARB_LOST  = 3'd6;

  localparam logic [7:0] SC_START      = 8'h08;
  localparam logic [7:0] SC_RSTART     = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK   = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_ACK   = 8'h28;
  localparam logic [7:0] SC_DATA_NACK  = 8'h30;
  localparam logic [7:0] SC_ARB_LOST   = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK   = 8'h40;
  localparam logic [7:0] SC_SLAR_NACK  = 8'h48;
  localparam logic [7:0] SC_RX_ACK     = 8'h50;
  localparam logic [7:0] SC_RX_NACK    = 8'h58;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [5:0] length;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic [7:0] status_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0] accept_code;
    logic       set_start;
    logic       set_stop;
    logic       ack_set;
    logic       ack_next;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_index;
    logic [2:0] master_status;
    logic       done_res;
  } out_word_t;

  typedef struct packed {
    logic [1:0] accept_code;
    logic       set_start;
    logic       set_stop;
    logic       ack_set;
    logic       ack_next;
    logic       tx_valid;
    logic       tx_from_ram;
    logic [7:0] tx_const;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_index;
    logic [2:0] master_status;
    logic       done_res;
  } stage_t;

endpackage

// ===== rtl/i2cmts_ram.sv =====
module i2cmts_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/i2cmts_ctrl.sv =====
module i2cmts_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  i2cmts_pkg::in_word_t            in_data,
  output i2cmts_pkg::stage_t              stage,
  output logic                            ram_we,
  output logic [i2cmts_pkg::AddrW-1:0]    ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [i2cmts_pkg::AddrW-1:0]    ram_raddr
);

  localparam int IdxW = i2cmts_pkg::IdxW;
  localparam int CmpW = i2cmts_pkg::CmpW;

  logic [IdxW-1:0] write_index_r, write_index_nxt;
  logic [IdxW-1:0] read_index_r, read_index_nxt;
  logic [IdxW-1:0] write_length_r, write_length_nxt;
  logic [IdxW-1:0] read_length_r, read_length_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            active_r, active_nxt;
  logic [6:0]      dev_r, dev_nxt;
  logic [7:0]      reg_r, reg_nxt;

  logic            fetch;
  logic [IdxW-1:0] fetch_idx;
  logic [CmpW-1:0] limit;
  logic [CmpW-1:0] load_pos;
  logic [CmpW-1:0] ri_inc;
  logic [CmpW-1:0] rx_pos;

  always_comb begin
    write_index_nxt  = write_index_r;
    read_index_nxt   = read_index_r;
    write_length_nxt = write_length_r;
    read_length_nxt  = read_length_r;
    status_nxt       = status_r;
    active_nxt       = active_r;
    dev_nxt          = dev_r;
    reg_nxt          = reg_r;
    stage            = '0;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    fetch            = 1'b0;
    fetch_idx        = write_index_r;
    ri_inc           = '0;
    rx_pos           = CmpW'(read_index_r);
    load_pos         = CmpW'(in_data.byte_index) + CmpW'(2);
    limit            = (in_data.func == i2cmts_pkg::FN_WRITE) ?
                       CmpW'(i2cmts_pkg::BufDepth - 3) : CmpW'(i2cmts_pkg::BufDepth - 1);

    case (in_data.func)
      i2cmts_pkg::FN_LOAD: begin
        if (!active_r && load_pos < CmpW'(i2cmts_pkg::BufDepth)) begin
          ram_we    = accept;
          ram_waddr = load_pos[i2cmts_pkg::AddrW-1:0];
          ram_wdata = in_data.data_byte;
        end
      end
      i2cmts_pkg::FN_WRITE, i2cmts_pkg::FN_READ: begin
        if (active_r) begin
          stage.accept_code = i2cmts_pkg::AC_BUSY;
        end else if (CmpW'(in_data.length) > limit) begin
          stage.accept_code = i2cmts_pkg::AC_BAD_LEN;
        end else begin
          dev_nxt = in_data.dev_addr;
          reg_nxt = in_data.reg_addr;
          if (in_data.func == i2cmts_pkg::FN_WRITE) begin
            write_length_nxt = IdxW'(CmpW'(in_data.length) + CmpW'(2));
            read_length_nxt  = '0;
          end else begin
            ram_we           = accept;
            ram_waddr        = i2cmts_pkg::AddrW'(2);
            ram_wdata        = {in_data.dev_addr, 1'b1};
            write_length_nxt = IdxW'(2);
            read_length_nxt  = IdxW'(in_data.length);
          end
          status_nxt      = i2cmts_pkg::MS_BUSY;
          active_nxt      = 1'b1;
          stage.set_start = 1'b1;
        end
      end
      default: begin
        if (active_r) begin
          case (in_data.status_code)
            i2cmts_pkg::SC_START: begin
              fetch     = 1'b1;
              fetch_idx = '0;
            end
            i2cmts_pkg::SC_RSTART: begin
              read_index_nxt = '0;
              fetch          = 1'b1;
            end
            i2cmts_pkg::SC_SLAW_ACK: begin
              if (write_length_r == IdxW'(1)) begin
                stage.set_stop = 1'b1;
                status_nxt     = i2cmts_pkg::MS_NO_DATA;
              end else begin
                fetch = 1'b1;
              end
            end
            i2cmts_pkg::SC_DATA_ACK: begin
              if (write_index_r < write_length_r) begin
                fetch = 1'b1;
              end else if (read_length_r != '0) begin
                stage.set_start = 1'b1;
              end else begin
                stage.set_stop = 1'b1;
                status_nxt     = i2cmts_pkg::MS_OK;
              end
            end
            i2cmts_pkg::SC_DATA_NACK: begin
              stage.set_stop = 1'b1;
              status_nxt     = i2cmts_pkg::MS_NACK_DATA;
            end
            i2cmts_pkg::SC_SLAR_ACK: begin
              ri_inc         = CmpW'(read_index_r) + CmpW'(1);
              stage.ack_set  = 1'b1;
              stage.ack_next = ri_inc < CmpW'(read_length_r);
            end
            i2cmts_pkg::SC_RX_ACK: begin
              stage.rx_valid = 1'b1;
              stage.rx_byte  = in_data.data_byte;
              stage.rx_index = rx_pos[4:0];
              if (read_index_r < IdxW'(i2cmts_pkg::BufDepth)) begin
                read_index_nxt = read_index_r + IdxW'(1);
              end
              ri_inc         = CmpW'(read_index_nxt) + CmpW'(1);
              stage.ack_set  = 1'b1;
              stage.ack_next = ri_inc < CmpW'(read_length_r);
            end
            i2cmts_pkg::SC_RX_NACK: begin
              stage.rx_valid = 1'b1;
              stage.rx_byte  = in_data.data_byte;
              stage.rx_index = rx_pos[4:0];
              if (read_index_r < IdxW'(i2cmts_pkg::BufDepth)) begin
                read_index_nxt = read_index_r + IdxW'(1);
              end
              stage.set_stop = 1'b1;
              status_nxt     = i2cmts_pkg::MS_OK;
            end
            i2cmts_pkg::SC_SLAW_NACK, i2cmts_pkg::SC_SLAR_NACK: begin
              stage.set_stop = 1'b1;
              status_nxt     = i2cmts_pkg::MS_NACK_ADDR;
            end
            default: begin
              status_nxt = i2cmts_pkg::MS_ARB_LOST;
            end
          endcase
          if (status_nxt != i2cmts_pkg::MS_BUSY) begin
            active_nxt     = 1'b0;
            stage.done_res = 1'b1;
          end
        end
      end
    endcase

    if (fetch) begin
      stage.tx_valid = 1'b1;
      if (fetch_idx == '0) begin
        stage.tx_const = {dev_r, 1'b0};
      end else if (fetch_idx == IdxW'(1)) begin
        stage.tx_const = reg_r;
      end else if (fetch_idx < IdxW'(i2cmts_pkg::BufDepth)) begin
        stage.tx_from_ram = 1'b1;
        ram_re            = accept;
        ram_raddr         = fetch_idx[i2cmts_pkg::AddrW-1:0];
      end
      if (fetch_idx < IdxW'(i2cmts_pkg::BufDepth)) begin
        write_index_nxt = fetch_idx + IdxW'(1);
      end else begin
        write_index_nxt = fetch_idx;
      end
    end

    stage.master_status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r  <= '0;
      read_index_r   <= '0;
      write_length_r <= '0;
      read_length_r  <= '0;
      status_r       <= i2cmts_pkg::MS_IDLE;
      active_r       <= 1'b0;
    end else if (accept) begin
      write_index_r  <= write_index_nxt;
      read_index_r   <= read_index_nxt;
      write_length_r <= write_length_nxt;
      read_length_r  <= read_length_nxt;
      status_r       <= status_nxt;
      active_r       <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dev_r <= dev_nxt;
      reg_r <= reg_nxt;
    end
  end

endmodule

// ===== rtl/i2cmts_out.sv =====
module i2cmts_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmts_pkg::stage_t    stage,
  input  logic [7:0]            ram_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmts_pkg::out_word_t out_data
);

  logic                  s1_valid_r, s1_valid_nxt;
  i2cmts_pkg::stage_t    s1_r;
  logic                  out_valid_r, out_valid_nxt;
  i2cmts_pkg::out_word_t out_r, out_nxt;
  logic                  s1_adv;
  logic                  accept;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_nxt.accept_code   = s1_r.accept_code;
    out_nxt.set_start     = s1_r.set_start;
    out_nxt.set_stop      = s1_r.set_stop;
    out_nxt.ack_set       = s1_r.ack_set;
    out_nxt.ack_next      = s1_r.ack_next;
    out_nxt.tx_valid      = s1_r.tx_valid;
    out_nxt.tx_byte       = s1_r.tx_from_ram ? ram_rdata : s1_r.tx_const;
    out_nxt.rx_valid      = s1_r.rx_valid;
    out_nxt.rx_byte       = s1_r.rx_byte;
    out_nxt.rx_index      = s1_r.rx_index;
    out_nxt.master_status = s1_r.master_status;
    out_nxt.done_res      = s1_r.done_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= stage;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/i2c_master_transfer_sequencer_unit.sv =====
// channel   ports                          word
// input     in_valid / in_ready / in_data   i2cmts_pkg::in_word_t
// result    out_valid / out_ready / out_data i2cmts_pkg::out_word_t
//
// one word per cycle unless out_ready stalls; a result passes s1_r, then out_r
// the registered buffer read sits between the decode stage and the output register
// reset clears indices, lengths, status and valid flags; buffer contents are not cleared
// a stalled output holds one result and one word in flight before in_ready drops
module i2c_master_transfer_sequencer_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmts_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmts_pkg::out_word_t out_data
);

  i2cmts_pkg::stage_t               stage;
  logic                             accept;
  logic                             ram_we;
  logic [i2cmts_pkg::AddrW-1:0]     ram_waddr;
  logic [7:0]                       ram_wdata;
  logic                             ram_re;
  logic [i2cmts_pkg::AddrW-1:0]     ram_raddr;
  logic [7:0]                       ram_rdata;

  assign accept = in_valid && in_ready;

  i2cmts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .stage     (stage),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  i2cmts_ram #(
    .Width (8),
    .Depth (i2cmts_pkg::BufDepth)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  i2cmts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .stage     (stage),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
